// ===== rtl/core/lot_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line overrun tracker package
// Shared types, register map codes and reset values for the tracker.
// ----------------------------------------------------------------------------
package lot_pkg;

    // register map: register i at byte address 4*i
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        REG_ENTER_THR  = 3'd0,
        REG_EXIT_THR   = 3'd1,
        REG_MIN_HOLD   = 3'd2,
        REG_RET_TMO    = 3'd3,
        REG_MIN_POWER  = 3'd4
    } reg_idx_t;

    localparam logic [7:0]  ENTER_THR_RST = 8'd130;
    localparam logic [7:0]  EXIT_THR_RST  = 8'd70;
    localparam logic [15:0] MIN_HOLD_RST  = 16'd30;
    localparam logic [15:0] RET_TMO_RST   = 16'd300;
    localparam logic [8:0]  MIN_POWER_RST = 9'd90;

    // angle wrap limits, in the 10-bit signed difference domain
    localparam logic signed [9:0] HALF_TURN = 10'sd180;
    localparam logic signed [9:0] FULL_TURN = 10'sd360;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 24;

    typedef struct packed {
        logic [7:0]  enter_thr;
        logic [7:0]  exit_thr;
        logic [15:0] min_hold;
        logic [15:0] ret_tmo;
        logic [8:0]  min_power;
    } cfg_t;

    typedef struct packed {
        logic               line_present;
        logic signed [8:0]  line_angle;
        logic [31:0]        now_ms;
        logic signed [9:0]  drive_angle;
        logic signed [9:0]  drive_power;
    } item_t;

    typedef struct packed {
        logic signed [9:0]  out_angle;
        logic signed [9:0]  out_power;
        logic               is_over_center;
        logic               is_returning;
    } result_t;

endpackage

// ===== rtl/core/line_overrun_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line overrun tracker
// Follows a robot across a field line and corrects its drive command.
// ----------------------------------------------------------------------------
// One sensor report word in gives one corrected drive word out. The block
// takes a new word every clock cycle while the output is not stalled: a word
// is held in the input register, the tracker state and correction are worked
// out from it combinationally, and the result lands in the output register.
// The sustained rate is one word per cycle, set by the tracker core, whose
// state advances once per word. Back-pressure on the output holds both
// registers; the input keeps accepting while the output word is being taken.
// Configuration registers (APB, byte address 4*index) should be written only
// while no word is in flight.
// ----------------------------------------------------------------------------
module line_overrun_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    // sensor report stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [8:0] line_angle, [40:9] now_ms, [50:41] drive_angle,
    // [60:51] drive_power, [63:61] zero
    input  logic [lot_pkg::IN_DATA_W-1:0]   s_tdata,
    // [0] line_present
    input  logic                            s_tuser,
    // corrected drive stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [9:0] out_angle, [19:10] out_power, [23:20] zero
    output logic [lot_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [0] is_over_center, [1] is_returning
    output logic [1:0]                      m_tuser,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lot_pkg::ADDR_W-1:0]      paddr,
    input  logic [lot_pkg::DATA_W-1:0]      pwdata,
    output logic [lot_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    lot_pkg::cfg_t    cfg;
    lot_pkg::item_t   in_item_reg;
    lot_pkg::result_t core_res;
    lot_pkg::result_t out_res_reg;
    logic             in_valid_reg, in_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic             s_take;

    // move the held word into the output register when that stage is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        if (s_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    lot_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // tracker state advances once per word, as it leaves the input register
    lot_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_res)
    );

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_item_reg.line_present <= s_tuser;
            in_item_reg.line_angle   <= s_tdata[8:0];
            in_item_reg.now_ms       <= s_tdata[40:9];
            in_item_reg.drive_angle  <= s_tdata[50:41];
            in_item_reg.drive_power  <= s_tdata[60:51];
        end
        if (advance)
            out_res_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.out_power, out_res_reg.out_angle};
    assign m_tuser  = {out_res_reg.is_returning, out_res_reg.is_over_center};

endmodule

// ===== rtl/core/lot_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line overrun tracker configuration registers
// APB register file holding thresholds, hold time, timeout and power floor.
// ----------------------------------------------------------------------------
module lot_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lot_pkg::ADDR_W-1:0]   paddr,
    input  logic [lot_pkg::DATA_W-1:0]   pwdata,
    output logic [lot_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output lot_pkg::cfg_t                cfg
);

    lot_pkg::cfg_t cfg_reg;
    lot_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[4:2])
                lot_pkg::REG_ENTER_THR: cfg_next.enter_thr = pwdata[7:0];
                lot_pkg::REG_EXIT_THR:  cfg_next.exit_thr  = pwdata[7:0];
                lot_pkg::REG_MIN_HOLD:  cfg_next.min_hold  = pwdata[15:0];
                lot_pkg::REG_RET_TMO:   cfg_next.ret_tmo   = pwdata[15:0];
                lot_pkg::REG_MIN_POWER: cfg_next.min_power = pwdata[8:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            lot_pkg::REG_ENTER_THR: prdata = {24'd0, cfg_reg.enter_thr};
            lot_pkg::REG_EXIT_THR:  prdata = {24'd0, cfg_reg.exit_thr};
            lot_pkg::REG_MIN_HOLD:  prdata = {16'd0, cfg_reg.min_hold};
            lot_pkg::REG_RET_TMO:   prdata = {16'd0, cfg_reg.ret_tmo};
            lot_pkg::REG_MIN_POWER: prdata = {23'd0, cfg_reg.min_power};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enter_thr <= lot_pkg::ENTER_THR_RST;
            cfg_reg.exit_thr  <= lot_pkg::EXIT_THR_RST;
            cfg_reg.min_hold  <= lot_pkg::MIN_HOLD_RST;
            cfg_reg.ret_tmo   <= lot_pkg::RET_TMO_RST;
            cfg_reg.min_power <= lot_pkg::MIN_POWER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/lot_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line overrun tracker core
// Tracker state, over-centre detection and drive command correction.
// ----------------------------------------------------------------------------
module lot_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  lot_pkg::item_t    item,
    input  lot_pkg::cfg_t     cfg,
    output lot_pkg::result_t  result
);

    logic              seen_reg,  seen_next;
    logic              over_reg,  over_next;
    logic              ret_reg,   ret_next;
    logic signed [8:0] appr_reg,  appr_next;
    logic signed [8:0] last_reg,  last_next;
    logic [31:0]       ostart_reg, ostart_next;
    logic [31:0]       rstart_reg, rstart_next;

    logic              fresh;
    logic              over_eff;
    logic signed [9:0] raw_diff;
    logic signed [9:0] wrap_diff;
    logic signed [9:0] abs_diff;
    logic [7:0]        diff_mag;
    logic [31:0]       over_elapsed;
    logic [31:0]       ret_elapsed;
    logic              correct;
    logic              floor_hit;

    // a new approach starts when neither tracking nor returning
    assign fresh    = !seen_reg && !ret_reg;
    assign over_eff = fresh ? 1'b0 : over_reg;

    always_comb
    begin
        raw_diff = (fresh ? {item.line_angle[8], item.line_angle}
                          : {appr_reg[8], appr_reg})
                 - {item.line_angle[8], item.line_angle};
        if (raw_diff > lot_pkg::HALF_TURN)
            wrap_diff = raw_diff - lot_pkg::FULL_TURN;
        else if (raw_diff < -lot_pkg::HALF_TURN)
            wrap_diff = raw_diff + lot_pkg::FULL_TURN;
        else
            wrap_diff = raw_diff;
        abs_diff = wrap_diff[9] ? -wrap_diff : wrap_diff;
        diff_mag = abs_diff[7:0];
    end

    assign over_elapsed = item.now_ms - ostart_reg;
    assign ret_elapsed  = item.now_ms - rstart_reg;

    always_comb
    begin
        seen_next   = seen_reg;
        over_next   = over_reg;
        ret_next    = ret_reg;
        appr_next   = appr_reg;
        last_next   = last_reg;
        ostart_next = ostart_reg;
        rstart_next = rstart_reg;
        if (item.line_present)
        begin
            if (fresh)
                appr_next = item.line_angle;
            seen_next = 1'b1;
            ret_next  = 1'b0;
            last_next = item.line_angle;
            over_next = over_eff;
            if (over_eff)
            begin
                if (diff_mag <= cfg.exit_thr)
                begin
                    over_next   = 1'b0;
                    ostart_next = '0;
                end
            end
            else if (diff_mag >= cfg.enter_thr)
            begin
                over_next   = 1'b1;
                ostart_next = item.now_ms;
            end
        end
        else if (seen_reg && over_reg)
        begin
            if (over_elapsed < {16'd0, cfg.min_hold})
            begin
                seen_next   = 1'b0;
                over_next   = 1'b0;
                ret_next    = 1'b0;
                ostart_next = '0;
            end
            else
            begin
                seen_next   = 1'b0;
                ret_next    = 1'b1;
                rstart_next = item.now_ms;
            end
        end
        else if (ret_reg)
        begin
            if (ret_elapsed > {16'd0, cfg.ret_tmo})
            begin
                seen_next   = 1'b0;
                over_next   = 1'b0;
                ret_next    = 1'b0;
                ostart_next = '0;
            end
        end
        else
        begin
            seen_next   = 1'b0;
            over_next   = 1'b0;
            ret_next    = 1'b0;
            ostart_next = '0;
        end
    end

    // return mode takes priority over the over-centre steer
    always_comb
    begin
        correct          = (item.line_present && over_next) || ret_next;
        result.out_angle = item.drive_angle;
        if (item.line_present && over_next)
            result.out_angle = {item.line_angle[8], item.line_angle};
        if (ret_next)
            result.out_angle = {last_reg[8], last_reg};
        floor_hit = $signed({item.drive_power[9], item.drive_power})
                  < $signed({2'b00, cfg.min_power});
        result.out_power      = (correct && floor_hit) ? {1'b0, cfg.min_power}
                                                       : item.drive_power;
        result.is_over_center = over_next;
        result.is_returning   = ret_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= 1'b0;
            over_reg   <= 1'b0;
            ret_reg    <= 1'b0;
            appr_reg   <= '0;
            last_reg   <= '0;
            ostart_reg <= '0;
            rstart_reg <= '0;
        end
        else if (step)
        begin
            seen_reg   <= seen_next;
            over_reg   <= over_next;
            ret_reg    <= ret_next;
            appr_reg   <= appr_next;
            last_reg   <= last_next;
            ostart_reg <= ostart_next;
            rstart_reg <= rstart_next;
        end
    end

    // tracking and return mode exclude each other
    assert property (@(posedge clk) disable iff (!rst_n) ret_reg |-> !seen_reg)
        else $error("return mode while line still tracked");

    // over-centre only lives inside a tracked or returning run
    assert property (@(posedge clk) disable iff (!rst_n) over_reg |-> (seen_reg || ret_reg))
        else $error("over-centre flag outside a run");

    // the start stamp is cleared whenever over-centre is not held
    assert property (@(posedge clk) disable iff (!rst_n) !over_reg |-> (ostart_reg == '0))
        else $error("stale over-centre start time");

    // a seen line always leaves the tracker in tracking state
    assert property (@(posedge clk) disable iff (!rst_n)
                     (step && item.line_present) |=> (seen_reg && !ret_reg))
        else $error("line seen but tracker not tracking");

endmodule
